@@ rtl/core/topl_pkg.sv @@
// Shared types and constants for the ticket ordered process list.
// Used by the controller, the datapath and the top level; depends on nothing.
package topl_pkg;

  localparam int PID_BITS    = 8;
  localparam int TICKET_BITS = 16;
  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_BITS   = $clog2(MAX_ENTRIES);
  localparam int LEN_BITS    = $clog2(MAX_ENTRIES + 1);

  localparam logic [TICKET_BITS-1:0] TICKET_MAX = '1;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_FIND   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // index counter operations
  localparam logic [2:0] IDX_HOLD  = 3'd0;
  localparam logic [2:0] IDX_ZERO  = 3'd1;
  localparam logic [2:0] IDX_INC   = 3'd2;
  localparam logic [2:0] IDX_DEC   = 3'd3;
  localparam logic [2:0] IDX_COUNT = 3'd4;

  // read address select
  localparam logic [1:0] RD_IDX  = 2'd0;
  localparam logic [1:0] RD_NEXT = 2'd1;
  localparam logic [1:0] RD_PREV = 2'd2;

  // write select
  localparam logic [1:0] WR_APPEND = 2'd0;
  localparam logic [1:0] WR_NEW    = 2'd1;
  localparam logic [1:0] WR_MOVE   = 2'd2;

  typedef struct packed {
    logic [1:0]             kind;
    logic [PID_BITS-1:0]    pid;
    logic [TICKET_BITS-1:0] tickets;
  } in_req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [TICKET_BITS-1:0] found_tickets;
    logic [LEN_BITS-1:0]    length;
  } out_res_t;

  typedef struct packed {
    logic [PID_BITS-1:0]    pid;
    logic [TICKET_BITS-1:0] tickets;
  } entry_t;

  typedef struct packed {
    logic       load_req;
    logic [2:0] idx_op;
    logic       pos_load;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       set_status;
    logic [1:0] status;
    logic       set_found;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       empty;
    logic       match;
    logic       less;
    logic       at_last;
    logic       at_pos;
    logic       out_busy;
  } sts_t;

endpackage

@@ rtl/core/ticket_ordered_process_list_core.sv @@
// Ticket ordered process list: up to 64 (pid, tickets) entries, head to tail.
// Append, full and empty go straight from dispatch to the result register;
// find scans the entries from the head, read then compare, until a match or
// the tail; insert and remove then move entries one by one after the scan.
// One request at a time: a new request is taken only once the result is loaded.
// Reset (synchronous, rst_n low) empties the list; entry storage is not cleared.
module ticket_ordered_process_list_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  topl_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output topl_pkg::out_res_t out_data
);

  // command and status between sequencer and datapath
  topl_pkg::cmd_t cmd;
  topl_pkg::sts_t sts;

  // Accept a request only when idle; scan the memory entry by entry
  // (read, then compare), move each entry by check, read and write, then
  // hold the result until taken.
  topl_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  topl_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.length <= topl_pkg::LEN_BITS'(topl_pkg::MAX_ENTRIES))
    else $error("length above capacity");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == topl_pkg::ST_FULL)
      |-> out_data.length == topl_pkg::LEN_BITS'(topl_pkg::MAX_ENTRIES))
    else $error("full status with room left");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == topl_pkg::ST_EMPTY) |-> out_data.length == '0)
    else $error("empty status with entries present");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while busy");

endmodule

@@ rtl/core/topl_datapath.sv @@
// Datapath of the ticket ordered process list: entry memory, count, index,
// request and result registers. Depends on topl_pkg.
module topl_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  topl_pkg::in_req_t in_data,
  input  logic              out_stall,
  input  topl_pkg::cmd_t    cmd,
  output topl_pkg::sts_t    sts,
  output logic              out_valid,
  output topl_pkg::out_res_t out_data
);

  topl_pkg::entry_t mem [topl_pkg::MAX_ENTRIES];

  topl_pkg::in_req_t                  req_r;
  topl_pkg::entry_t                   rd_data_r;
  logic [topl_pkg::LEN_BITS-1:0]      count_r, count_nxt;
  logic [topl_pkg::LEN_BITS-1:0]      idx_r, idx_nxt;
  logic [topl_pkg::LEN_BITS-1:0]      pos_r;
  logic [1:0]                         res_status_r;
  logic [topl_pkg::TICKET_BITS-1:0]   res_found_r;
  logic                               out_valid_r;
  topl_pkg::out_res_t                 out_r;
  logic [topl_pkg::ADDR_BITS-1:0]     rd_addr, wr_addr;
  topl_pkg::entry_t                   wr_data;

  always_comb begin
    unique case (cmd.rd_sel)
      topl_pkg::RD_NEXT: rd_addr = idx_r[topl_pkg::ADDR_BITS-1:0] + 1'b1;
      topl_pkg::RD_PREV: rd_addr = idx_r[topl_pkg::ADDR_BITS-1:0] - 1'b1;
      default:           rd_addr = idx_r[topl_pkg::ADDR_BITS-1:0];
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      topl_pkg::WR_APPEND: begin
        wr_addr = count_r[topl_pkg::ADDR_BITS-1:0];
        wr_data = {req_r.pid, topl_pkg::TICKET_MAX};
      end
      topl_pkg::WR_NEW: begin
        wr_addr = idx_r[topl_pkg::ADDR_BITS-1:0];
        wr_data = {req_r.pid, req_r.tickets};
      end
      default: begin
        wr_addr = idx_r[topl_pkg::ADDR_BITS-1:0];
        wr_data = rd_data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    unique case (cmd.idx_op)
      topl_pkg::IDX_ZERO:  idx_nxt = '0;
      topl_pkg::IDX_INC:   idx_nxt = idx_r + 1'b1;
      topl_pkg::IDX_DEC:   idx_nxt = idx_r - 1'b1;
      topl_pkg::IDX_COUNT: idx_nxt = count_r;
      default:             idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.out_load | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.pos_load) begin
      pos_r <= idx_r;
    end
    if (cmd.load_req) begin
      req_r        <= in_data;
      res_status_r <= topl_pkg::ST_OK;
      res_found_r  <= '0;
    end else begin
      if (cmd.set_status) begin
        res_status_r <= cmd.status;
      end
      if (cmd.set_found) begin
        res_found_r <= rd_data_r.tickets;
      end
    end
    if (cmd.out_load) begin
      out_r <= {res_status_r, res_found_r, count_r};
    end
  end

  assign sts.kind     = req_r.kind;
  assign sts.full     = (count_r == topl_pkg::LEN_BITS'(topl_pkg::MAX_ENTRIES));
  assign sts.empty    = (count_r == '0);
  assign sts.match    = (rd_data_r.pid == req_r.pid);
  assign sts.less     = (rd_data_r.tickets < req_r.tickets);
  assign sts.at_last  = ((idx_r + 1'b1) == count_r);
  assign sts.at_pos   = (idx_r == pos_r);
  assign sts.out_busy = out_valid_r & out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/core/topl_controller.sv @@
// Sequencer of the ticket ordered process list: scans, shifts and result hand-off.
// Depends on topl_pkg; drives the datapath through cmd_t and reads sts_t.
module topl_controller (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  topl_pkg::sts_t sts,
  output topl_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CHK = 4'd3;
  localparam logic [3:0] S_INS_POS  = 4'd4;
  localparam logic [3:0] S_INS_CHK  = 4'd5;
  localparam logic [3:0] S_INS_RD   = 4'd6;
  localparam logic [3:0] S_INS_WR   = 4'd7;
  localparam logic [3:0] S_RM_CHK   = 4'd8;
  localparam logic [3:0] S_RM_RD    = 4'd9;
  localparam logic [3:0] S_RM_WR    = 4'd10;
  localparam logic [3:0] S_FINISH   = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       is_add;

  assign is_add   = (sts.kind == topl_pkg::KIND_APPEND) || (sts.kind == topl_pkg::KIND_INSERT);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.idx_op = topl_pkg::IDX_ZERO;
        state_nxt  = S_FINISH;
        if (is_add && sts.full) begin
          cmd.set_status = 1'b1;
          cmd.status     = topl_pkg::ST_FULL;
        end else if (!is_add && sts.empty) begin
          cmd.set_status = 1'b1;
          cmd.status     = topl_pkg::ST_EMPTY;
        end else if (sts.kind == topl_pkg::KIND_APPEND) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = topl_pkg::WR_APPEND;
          cmd.cnt_inc = 1'b1;
        end else if (sts.kind == topl_pkg::KIND_INSERT && sts.empty) begin
          state_nxt = S_INS_POS;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = topl_pkg::RD_IDX;
        state_nxt  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.kind == topl_pkg::KIND_INSERT) begin
          // stop on the first entry with fewer tickets, else fall off the tail
          if (sts.less) begin
            state_nxt = S_INS_POS;
          end else begin
            cmd.idx_op = topl_pkg::IDX_INC;
            state_nxt  = sts.at_last ? S_INS_POS : S_SCAN_RD;
          end
        end else if (sts.match) begin
          if (sts.kind == topl_pkg::KIND_FIND) begin
            cmd.set_found = 1'b1;
            state_nxt     = S_FINISH;
          end else begin
            state_nxt = S_RM_CHK;
          end
        end else if (sts.at_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = topl_pkg::ST_NOT_FOUND;
          state_nxt      = S_FINISH;
        end else begin
          cmd.idx_op = topl_pkg::IDX_INC;
          state_nxt  = S_SCAN_RD;
        end
      end
      S_INS_POS: begin
        cmd.pos_load = 1'b1;
        cmd.idx_op   = topl_pkg::IDX_COUNT;
        state_nxt    = S_INS_CHK;
      end
      S_INS_CHK: begin
        if (sts.at_pos) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = topl_pkg::WR_NEW;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          state_nxt = S_INS_RD;
        end
      end
      S_INS_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = topl_pkg::RD_PREV;
        state_nxt  = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = topl_pkg::WR_MOVE;
        cmd.idx_op = topl_pkg::IDX_DEC;
        state_nxt  = S_INS_CHK;
      end
      S_RM_CHK: begin
        if (sts.at_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          state_nxt = S_RM_RD;
        end
      end
      S_RM_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = topl_pkg::RD_NEXT;
        state_nxt  = S_RM_WR;
      end
      S_RM_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = topl_pkg::WR_MOVE;
        cmd.idx_op = topl_pkg::IDX_INC;
        state_nxt  = S_RM_CHK;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ test/tb_ticket_ordered_process_list_core.sv @@
// Self-checking testbench for ticket_ordered_process_list_core.
// Holds its own model of the ordered list; depends on topl_pkg and the core.
module tb_ticket_ordered_process_list_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  topl_pkg::in_req_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  topl_pkg::out_res_t out_data;

  // idle and stall odds, in percent
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // shadow copy of the list, head at index 0
  topl_pkg::entry_t list_shadow[$];
  topl_pkg::out_res_t pending_results[$];

  ticket_ordered_process_list_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5ns clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Apply one request to the shadow list and return the expected result.
  function automatic topl_pkg::out_res_t apply_request(topl_pkg::in_req_t req);
    topl_pkg::out_res_t res;
    int pos;
    res = '0;
    res.status = topl_pkg::ST_OK;
    if (req.kind == topl_pkg::KIND_APPEND || req.kind == topl_pkg::KIND_INSERT) begin
      if (list_shadow.size() >= topl_pkg::MAX_ENTRIES) begin
        res.status = topl_pkg::ST_FULL;
      end else if (req.kind == topl_pkg::KIND_APPEND) begin
        list_shadow.push_back('{pid: req.pid, tickets: topl_pkg::TICKET_MAX});
      end else begin
        // go before the first strictly poorer entry; ties stay ahead
        pos = list_shadow.size();
        foreach (list_shadow[i]) begin
          if (list_shadow[i].tickets < req.tickets && pos == list_shadow.size()) pos = i;
        end
        list_shadow.insert(pos, '{pid: req.pid, tickets: req.tickets});
      end
    end else begin
      if (list_shadow.size() == 0) begin
        res.status = topl_pkg::ST_EMPTY;
      end else begin
        pos = -1;
        foreach (list_shadow[i]) begin
          if (list_shadow[i].pid == req.pid && pos < 0) pos = i;
        end
        if (pos < 0) begin
          res.status = topl_pkg::ST_NOT_FOUND;
        end else if (req.kind == topl_pkg::KIND_FIND) begin
          res.found_tickets = list_shadow[pos].tickets;
        end else begin
          list_shadow.delete(pos);
        end
      end
    end
    res.length = topl_pkg::LEN_BITS'(list_shadow.size());
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d, expected %0d at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // Drive stall at the falling edge; a hold-off request overrides the odds.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    topl_pkg::out_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_data.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.found_tickets !== want.found_tickets)
          report_mismatch("found_tickets", out_data.found_tickets, want.found_tickets);
        if (out_data.length !== want.length)
          report_mismatch("length", out_data.length, want.length);
      end
    end
  end

  // Offer one request after an optional idle stretch; hold it until accepted.
  task automatic send_request(logic [1:0] kind, logic [topl_pkg::PID_BITS-1:0] pid,
                              logic [topl_pkg::TICKET_BITS-1:0] tickets);
    topl_pkg::in_req_t req;
    req = '{kind: kind, pid: pid, tickets: tickets};
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_request(req));
    @(negedge clk);
  endtask

  // Drop valid at the falling edge.
  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Random pid from a narrow pool so that removes and finds hit often.
  function automatic logic [topl_pkg::PID_BITS-1:0] pick_pid();
    if ($urandom_range(9) == 0) return topl_pkg::PID_BITS'($urandom);
    return topl_pkg::PID_BITS'($urandom_range(15));
  endfunction

  task automatic test_directed();
    send_request(topl_pkg::KIND_REMOVE, 8'd5, 16'd0);     // empty list
    send_request(topl_pkg::KIND_FIND, 8'hFF, 16'hFFFF);   // empty list
    send_request(topl_pkg::KIND_INSERT, 8'd0, 16'd0);
    send_request(topl_pkg::KIND_REMOVE, 8'd0, 16'd0);     // only entry leaves
    send_request(topl_pkg::KIND_APPEND, 8'hFF, 16'h1234); // tickets ignored
    send_request(topl_pkg::KIND_INSERT, 8'd1, 16'hFFFF);  // tie goes later
    send_request(topl_pkg::KIND_INSERT, 8'd2, 16'h8000);
    send_request(topl_pkg::KIND_INSERT, 8'd3, 16'h0001);
    send_request(topl_pkg::KIND_INSERT, 8'd4, 16'h0000);  // past all entries
    send_request(topl_pkg::KIND_INSERT, 8'd5, 16'h7FFF);
    send_request(topl_pkg::KIND_FIND, 8'd5, 16'hAAAA);
    send_request(topl_pkg::KIND_FIND, 8'hFF, 16'd0);
    send_request(topl_pkg::KIND_FIND, 8'd77, 16'd0);      // no match
    send_request(topl_pkg::KIND_REMOVE, 8'd77, 16'd0);    // no match
    send_request(topl_pkg::KIND_REMOVE, 8'd2, 16'd0);
    send_request(topl_pkg::KIND_REMOVE, 8'hFF, 16'd0);
    send_request(topl_pkg::KIND_FIND, 8'd4, 16'd0);
    wait_drained();
  endtask

  // Fill to capacity, probe the full status, then drain to empty.
  task automatic test_full_and_empty();
    while (list_shadow.size() < topl_pkg::MAX_ENTRIES)
      send_request($urandom_range(1) ? topl_pkg::KIND_INSERT : topl_pkg::KIND_APPEND,
                   pick_pid(), 16'($urandom));
    send_request(topl_pkg::KIND_APPEND, 8'd1, 16'd0);
    send_request(topl_pkg::KIND_INSERT, 8'd1, 16'hFFFF);
    send_request(topl_pkg::KIND_FIND, list_shadow[topl_pkg::MAX_ENTRIES-1].pid, 16'd0);
    while (list_shadow.size() > 0)
      send_request(topl_pkg::KIND_REMOVE,
                   list_shadow[$urandom_range(list_shadow.size()-1)].pid, 16'd0);
    send_request(topl_pkg::KIND_REMOVE, 8'd1, 16'd0);
    wait_drained();
  endtask

  // Random mix of adds, removes of listed pids while any, finds and random removes.
  task automatic test_random(int unsigned count);
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 50)
        send_request(roll < 15 ? topl_pkg::KIND_APPEND : topl_pkg::KIND_INSERT,
                     pick_pid(), 16'($urandom));
      else if (roll < 80 && list_shadow.size() > 0)
        send_request(topl_pkg::KIND_REMOVE,
                     list_shadow[$urandom_range(list_shadow.size()-1)].pid, 16'($urandom));
      else
        send_request(roll < 90 ? topl_pkg::KIND_FIND : topl_pkg::KIND_REMOVE,
                     pick_pid(), 16'($urandom));
    end
  endtask

  // Stall the output for a long stretch while requests keep coming.
  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    stop_sending();
    @(negedge clk);
    hold_off_cycles <= 400;
    test_random(30);
    wait_drained();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_full_and_empty();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(150);
    send_idle_pct = 84; recv_stall_pct = 0;  test_random(120);
    wait_drained();     // sender pauses until everything is back
    send_idle_pct = 0;  recv_stall_pct = 84; test_random(120);
    send_idle_pct = 9;  recv_stall_pct = 9;  test_random(120);
    test_back_pressure();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(40);
    wait_drained();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ ticket_ordered_process_list_core.f @@
rtl/core/topl_pkg.sv
rtl/core/topl_datapath.sv
rtl/core/topl_controller.sv
rtl/core/ticket_ordered_process_list_core.sv
test/tb_ticket_ordered_process_list_core.sv
